// ===== rtl/sjfd_pkg.sv =====
// Shared types and constants for the shortest-job-first dispatcher.
// Used by sjfd_ctrl, sjfd_dpath and sjf_multi_cpu_dispatcher_top; no dependencies.
package sjfd_pkg;

  // Operation codes carried on s_axis_tuser
  localparam int unsigned OP_W = 2;
  localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
  localparam logic [OP_W-1:0] OP_SCHED = 2'd1;
  localparam logic [OP_W-1:0] OP_REL   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPUS    = 2'd1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0] QUANTUM_RST = 8'd5;
  localparam logic [3:0] CPUS_RST    = 4'd1;

  // Busy counter fits 0..15
  localparam int unsigned BUSY_W   = 4;
  localparam int unsigned BUSY_MAX = 15;

  // Dispatches per schedule request
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned RES_W       = $clog2(MAX_RESULTS);

  localparam int unsigned ID_W  = 8;
  localparam int unsigned SL_W  = 8;
  localparam int unsigned REM_W = 16;
  localparam int unsigned IN_BURST_W = 16;

  // Controller -> datapath
  typedef struct packed {
    logic accept;         // input request taken
    logic enq_write;      // append entry at fill count
    logic cpu_free;       // release one CPU
    logic scan_init;
    logic scan_step;
    logic shift_init;
    logic shift_step;
    logic load_dispatch;  // load dispatch result into output register
    logic load_reject;    // load table-full result
    logic last;           // tlast of the loaded result
  } sjfd_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic full;
    logic can_dispatch;   // entry ready and a CPU free
    logic more_ok;        // still true after one more dispatch
    logic scan_done;
    logic shift_done;
    logic out_free;       // output register can take a result
  } sjfd_status_t;

endpackage

// ===== rtl/sjfd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sjfd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/sjfd_ctrl.sv =====
// Controller state machine of the dispatcher: sequences enqueue, release, scan, shift, emit and table-full reject.
// Depends on sjfd_pkg.
module sjfd_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 op_i,
  input  sjfd_pkg::sjfd_status_t     st_i,
  output sjfd_pkg::sjfd_cmd_t        cmd_o
);
  import sjfd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_EMIT   = 3'd3;
  localparam logic [2:0] ST_REJECT = 3'd4;

  localparam logic [RES_W-1:0] RES_LAST = RES_W'(MAX_RESULTS - 1);

  logic [2:0]       state_q, state_d;
  logic [RES_W-1:0] n_q, n_d;
  logic             last;

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    last       = (n_q == RES_LAST) || !st_i.more_ok;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (op_i)
            OP_ENQ: begin
              if (st_i.full) begin
                state_d = ST_REJECT;
              end else begin
                cmd_o.enq_write = 1'b1;
              end
            end
            OP_SCHED: begin
              if (st_i.can_dispatch) begin
                cmd_o.scan_init = 1'b1;
                n_d             = '0;
                state_d         = ST_SCAN;
              end
            end
            OP_REL: begin
              cmd_o.cpu_free = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (st_i.scan_done) begin
          cmd_o.shift_init = 1'b1;
          state_d          = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (st_i.shift_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.load_dispatch = 1'b1;
          cmd_o.last          = last;
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.scan_init = 1'b1;
            n_d             = n_q + RES_W'(1);
            state_d         = ST_SCAN;
          end
        end
      end
      ST_REJECT: begin
        if (st_i.out_free) begin
          cmd_o.load_reject = 1'b1;
          cmd_o.last        = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
    end
  end

endmodule

// ===== rtl/sjfd_dpath.sv =====
// Datapath of the dispatcher: ready table RAM, fill and busy counters, scan and
// shift pointers, config registers and the output register. Depends on sjfd_pkg, sjfd_ram.
module sjfd_dpath #(
  parameter int unsigned READY_DEPTH = 16,
  parameter int unsigned MAX_CPUS    = 8,
  parameter int unsigned BURST_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [sjfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]                 pid_i,
  input  logic [15:0]                burst_i,
  input  sjfd_pkg::sjfd_cmd_t        cmd_i,
  output sjfd_pkg::sjfd_status_t     st_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic                       out_status_o,
  output logic [7:0]                 out_id_o,
  output logic [7:0]                 out_slice_o,
  output logic [15:0]                out_rem_o,
  output logic                       out_last_o
);
  import sjfd_pkg::*;

  localparam int unsigned AW = $clog2(READY_DEPTH);
  localparam int unsigned CW = $clog2(READY_DEPTH + 1);
  localparam int unsigned EW = ID_W + BURST_BITS;
  localparam int unsigned MW = (BURST_BITS > SL_W) ? BURST_BITS : SL_W;
  localparam logic [BUSY_W-1:0] CPU_CAP =
    (MAX_CPUS < BUSY_MAX) ? BUSY_W'(MAX_CPUS) : BUSY_W'(BUSY_MAX);

  // Config and counters
  logic [7:0]          quantum_q;
  logic [BUSY_W-1:0]   cpus_q;
  logic [BUSY_W-1:0]   busy_q, busy_d;
  logic [CW-1:0]       count_q, count_d;
  logic [BUSY_W-1:0]   lim;

  // Latched request payload (for table-full result)
  logic [ID_W-1:0]       pid_q;
  logic [IN_BURST_W-1:0] burst_q;

  // Scan
  logic [CW-1:0]         scan_idx_q;
  logic                  dv_q, first_q;
  logic [AW-1:0]         dv_idx_q;
  logic [AW-1:0]         best_idx_q;
  logic [BURST_BITS-1:0] best_burst_q;
  logic [ID_W-1:0]       best_id_q;
  logic                  scan_issue;

  // Shift
  logic [CW-1:0] sh_idx_q;
  logic          sdv_q;
  logic [AW-1:0] sdv_idx_q;
  logic          shift_issue;

  // RAM
  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [EW-1:0]         wr_data, rd_data;
  logic [BURST_BITS-1:0] rd_burst;
  logic [ID_W-1:0]       rd_id;

  // Slice
  logic [MW-1:0] b_ext, q_ext, slice_w, rem_w;

  // Output register
  logic             out_valid_q;
  logic             out_status_q, out_last_q;
  logic [ID_W-1:0]  out_id_q;
  logic [SL_W-1:0]  out_slice_q;
  logic [REM_W-1:0] out_rem_q;
  logic             out_free;

  assign lim         = (cpus_q > CPU_CAP) ? CPU_CAP : cpus_q;
  assign scan_issue  = scan_idx_q < count_q;
  assign shift_issue = sh_idx_q < count_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign rd_burst = rd_data[BURST_BITS-1:0];
  assign rd_id    = rd_data[EW-1:BURST_BITS];

  assign rd_en   = (cmd_i.scan_step && scan_issue) || (cmd_i.shift_step && shift_issue);
  assign rd_addr = cmd_i.shift_step ? sh_idx_q[AW-1:0] : scan_idx_q[AW-1:0];
  assign wr_en   = cmd_i.enq_write || (cmd_i.shift_step && sdv_q);
  assign wr_addr = cmd_i.enq_write ? count_q[AW-1:0] : (sdv_idx_q - AW'(1));
  assign wr_data = cmd_i.enq_write ? {pid_i, BURST_BITS'(burst_i)} : rd_data;

  sjfd_ram #(
    .WIDTH (EW),
    .DEPTH (READY_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // min(burst, quantum) and remainder
  assign b_ext   = MW'(best_burst_q);
  assign q_ext   = MW'(quantum_q);
  assign slice_w = (b_ext < q_ext) ? b_ext : q_ext;
  assign rem_w   = b_ext - slice_w;

  always_comb begin
    st_o.full         = (count_q == CW'(READY_DEPTH));
    st_o.can_dispatch = (count_q != '0) && (busy_q < lim);
    st_o.more_ok      = (count_q > CW'(1)) &&
                        (({1'b0, busy_q} + (BUSY_W + 1)'(1)) < {1'b0, lim});
    st_o.scan_done    = !scan_issue && !dv_q;
    st_o.shift_done   = !shift_issue && !sdv_q;
    st_o.out_free     = out_free;
  end

  always_comb begin
    count_d = count_q;
    busy_d  = busy_q;
    if (cmd_i.enq_write) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.load_dispatch) begin
      count_d = count_q - CW'(1);
      busy_d  = busy_q + BUSY_W'(1);
    end
    if (cmd_i.cpu_free && (busy_q != '0)) begin
      busy_d = busy_q - BUSY_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q   <= QUANTUM_RST;
      cpus_q      <= CPUS_RST;
      count_q     <= '0;
      busy_q      <= '0;
      scan_idx_q  <= '0;
      dv_q        <= 1'b0;
      first_q     <= 1'b0;
      sh_idx_q    <= '0;
      sdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_QUANTUM) begin
          quantum_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_CPUS) begin
          cpus_q <= cfg_data_i[BUSY_W-1:0];
        end
      end
      count_q <= count_d;
      busy_q  <= busy_d;

      if (cmd_i.scan_init) begin
        scan_idx_q <= '0;
        dv_q       <= 1'b0;
        first_q    <= 1'b1;
      end else if (cmd_i.scan_step) begin
        if (scan_issue) begin
          scan_idx_q <= scan_idx_q + CW'(1);
        end
        dv_q <= scan_issue;
        if (dv_q) begin
          first_q <= 1'b0;
        end
      end

      if (cmd_i.shift_init) begin
        sh_idx_q <= CW'(best_idx_q) + CW'(1);
        sdv_q    <= 1'b0;
      end else if (cmd_i.shift_step) begin
        if (shift_issue) begin
          sh_idx_q <= sh_idx_q + CW'(1);
        end
        sdv_q <= shift_issue;
      end

      if (cmd_i.load_dispatch || cmd_i.load_reject) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pid_q   <= pid_i;
      burst_q <= burst_i;
    end
    if (cmd_i.scan_step) begin
      dv_idx_q <= scan_idx_q[AW-1:0];
      // strict compare keeps the earliest arrival on a tie
      if (dv_q && (first_q || (rd_burst < best_burst_q))) begin
        best_idx_q   <= dv_idx_q;
        best_burst_q <= rd_burst;
        best_id_q    <= rd_id;
      end
    end
    if (cmd_i.shift_step) begin
      sdv_idx_q <= sh_idx_q[AW-1:0];
    end
    if (cmd_i.load_dispatch) begin
      out_status_q <= 1'b0;
      out_id_q     <= best_id_q;
      out_slice_q  <= slice_w[SL_W-1:0];
      out_rem_q    <= REM_W'(rem_w);
      out_last_q   <= cmd_i.last;
    end else if (cmd_i.load_reject) begin
      out_status_q <= 1'b1;
      out_id_q     <= pid_q;
      out_slice_q  <= '0;
      out_rem_q    <= burst_q;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_id_o     = out_id_q;
  assign out_slice_o  = out_slice_q;
  assign out_rem_o    = out_rem_q;
  assign out_last_o   = out_last_q;

endmodule

// ===== rtl/sjf_multi_cpu_dispatcher_top.sv =====
// Top level of the shortest-job-first multi-CPU dispatcher.
// Depends on sjfd_pkg, sjfd_ctrl, sjfd_dpath (and through it sjfd_ram).
//
// The block keeps a table of ready processes (id and next burst) in arrival
// order plus a count of busy CPUs. Requests arrive on the s_axis stream with
// the operation on tuser: enqueue, schedule or release one CPU. Enqueue and
// release give no result, except that an enqueue into a full table gives one
// result with tuser = 1. A schedule request dispatches up to eight processes
// while entries are ready and fewer than cpu_count CPUs (capped at MAX_CPUS)
// are busy, always the shortest burst (earliest arrival on a tie); each result
// carries the id, the slice min(burst, time_quantum) and the burst left over,
// and tlast marks the final result of the request. The ready table is a RAM
// with one read and one write port: each dispatch scans the N valid entries
// one per cycle, then closes the gap left by the chosen entry one entry per
// cycle. The next request is taken as soon as the last result sits in the
// output register. Configuration writes are taken at any time (cfg_ready_o is
// tied high) and are meant to happen while the block is idle. No clearing
// pass is needed after reset.
module sjf_multi_cpu_dispatcher_top #(
  parameter int unsigned READY_DEPTH = 16,
  parameter int unsigned MAX_CPUS    = 8,
  parameter int unsigned BURST_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] process_id, [23:8] burst_length
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] granted_id, [15:8] slice_length,
                                      // [31:16] remaining_burst
  output logic        m_axis_tuser,   // [0] status (1 = table full)
  output logic        m_axis_tlast,   // last_result
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,    // 0 time_quantum, 1 cpu_count
  input  logic [7:0]  cfg_data_i
);
  import sjfd_pkg::*;

  sjfd_cmd_t    cmd;
  sjfd_status_t st;

  logic [ID_W-1:0]  out_id;
  logic [SL_W-1:0]  out_slice;
  logic [REM_W-1:0] out_rem;

  assign cfg_ready_o = 1'b1;

  // Sequencer: accepts requests only when idle
  sjfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Table, counters, slice math and the result register
  sjfd_dpath #(
    .READY_DEPTH (READY_DEPTH),
    .MAX_CPUS    (MAX_CPUS),
    .BURST_BITS  (BURST_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pid_i        (s_axis_tdata[7:0]),
    .burst_i      (s_axis_tdata[23:8]),
    .cmd_i        (cmd),
    .st_o         (st),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_id_o     (out_id),
    .out_slice_o  (out_slice),
    .out_rem_o    (out_rem),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_rem, out_slice, out_id};

  // A dispatch only happens with an entry ready and a CPU free
  a_dispatch_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_dispatch |-> st.can_dispatch)
    else $error("dispatch without ready entry or free CPU");

  // Never append to a full table
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.enq_write |-> !st.full)
    else $error("enqueue write into full table");

  // Table port users and result loads never overlap
  a_single_user: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.enq_write, cmd.scan_step, cmd.shift_step,
              cmd.load_dispatch, cmd.load_reject}))
    else $error("conflicting datapath commands");

  // A table-full result is always the only result of its request
  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("table-full result without tlast");

endmodule
